// ===== rtl/core/gmbr_pkg.sv =====
package gmbr_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int CELLS    = MAX_ROWS * MAX_COLS;
   localparam int CELL_W   = $clog2(CELLS);
   localparam int CNT_W    = CELL_W + 1;
   localparam int ROWN_W   = $clog2(MAX_ROWS + 1);
   localparam int COLN_W   = $clog2(MAX_COLS + 1);
   localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int QUEUE_W  = CELL_W + COL_W;
   localparam int REM_W    = COLN_W + 1;
   localparam int BIT_W    = (CELL_W > 1) ? $clog2(CELL_W) : 1;
   localparam int CSR_W    = 7;
   localparam int PATH_W   = 12;

   localparam logic       FUNC_LOAD   = 1'b0;
   localparam logic       FUNC_FETCH  = 1'b1;

   localparam logic [1:0] KIND_FREE   = 2'd0;
   localparam logic [1:0] KIND_WALL   = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;
   localparam logic [1:0] KIND_TARGET = 2'd3;

   localparam logic       RES_SUMMARY = 1'b0;
   localparam logic       RES_MOVE    = 1'b1;

   localparam logic [1:0] DIR_UP      = 2'd0;
   localparam logic [1:0] DIR_DOWN    = 2'd1;
   localparam logic [1:0] DIR_LEFT    = 2'd2;
   localparam logic [1:0] DIR_RIGHT   = 2'd3;

   localparam logic       CSR_ROWS    = 1'b0;
   localparam logic       CSR_COLS    = 1'b1;

   typedef struct packed {
      logic       func;
      logic [1:0] cell_kind;
   } req_type;

   typedef struct packed {
      logic              result_kind;
      logic              reachable;
      logic [PATH_W-1:0] path_length;
      logic [1:0]        move_dir;
      logic              move_valid;
      logic              last_move;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_INIT,
      ST_POP,
      ST_FETCH_Q,
      ST_NB,
      ST_CHK,
      ST_TR_RD,
      ST_TR_WR,
      ST_DONE,
      ST_MOVE
   } state_type;

endpackage

// ===== rtl/core/gmbr_ram.sv =====
module gmbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/grid_maze_bfs_router.sv =====
// Lee maze router: breadth-first search on a 4-neighbor grid.
// req channel: one word per item. func load delivers the next grid cell in
//   raster order (free, wall, start, target); func fetch asks for the next
//   move of the routed path. Only the last cell of the grid gives a result,
//   the search summary.
// rsp channel: summary words (reachable, path length) and move words
//   (direction, move_valid, last_move), held in an output register.
// csr channel: index 0 rows, index 1 cols; always ready, one write per cycle.
// After the last cell: a restoring divider splits the start position into
//   row/column, an init step follows, then each dequeued cell checks its
//   neighbors (a visited-map read per in-grid neighbor and a write when it is
//   new; no access for a neighbor off the grid), and each path move is traced
//   back through the parent memory onto the move stack.
// A fetch reads the move stack; with no move left it answers with last_move set.
// Reset clears control state only; the memories need no clearing pass since
//   every visited entry is written by the load before the search reads it.
// When rsp stalls, req_ready drops until the waiting word is taken.
module grid_maze_bfs_router (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  gmbr_pkg::req_type         req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output gmbr_pkg::rsp_type         rsp_word,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [gmbr_pkg::CSR_W-1:0] csr_data
);

   localparam int CELL_W  = gmbr_pkg::CELL_W;
   localparam int CNT_W   = gmbr_pkg::CNT_W;
   localparam int COL_W   = gmbr_pkg::COL_W;
   localparam int QUEUE_W = gmbr_pkg::QUEUE_W;
   localparam int REM_W   = gmbr_pkg::REM_W;
   localparam int BIT_W   = gmbr_pkg::BIT_W;

   gmbr_pkg::state_type state_ff, state_in;

   logic [gmbr_pkg::CSR_W-1:0] rows_ff, cols_ff;
   logic [CELL_W-1:0]  load_pos_ff, load_pos_in;
   logic [CELL_W-1:0]  start_ff, start_in, target_ff, target_in;
   logic [CNT_W-1:0]   moves_left_ff, moves_left_in;
   logic [CELL_W-1:0]  s_ff, s_in, t_ff, t_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [CNT_W-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [CELL_W-1:0]  v_ff, v_in, u_ff, u_in;
   logic [COL_W-1:0]   vc_ff, vc_in, uc_ff, uc_in;
   logic [1:0]         k_ff, k_in, ud_ff, ud_in;
   logic               found_ff, found_in;
   logic [CNT_W-1:0]   cur_ff, cur_in, len_ff, len_in;
   logic               rsp_valid_ff, rsp_valid_in;
   gmbr_pkg::rsp_type  rsp_ff, rsp_in;

   // grid size as the search sees it
   logic [gmbr_pkg::ROWN_W-1:0] rows_eff;
   logic [gmbr_pkg::COLN_W-1:0] cols_eff;
   logic [CNT_W-1:0]            total, cols_ext;

   logic req_fire, slot_free, is_load, is_fetch, last_cell;
   logic [CELL_W-1:0] start_upd, target_upd;
   logic [REM_W-1:0]  rem_sh;

   // neighbor candidate
   logic              nb_ok;
   logic [CNT_W-1:0]  nb_u;
   logic [COL_W-1:0]  nb_uc;
   logic [1:0]        nb_d;
   logic [CNT_W-1:0]  tr_next;

   // memory ports
   logic              vis_we, vis_wd, vis_re, vis_rd;
   logic [CELL_W-1:0] vis_wa, vis_ra;
   logic              q_we, q_re;
   logic [CELL_W-1:0] q_wa, q_ra;
   logic [QUEUE_W-1:0] q_wd, q_rd;
   logic              par_we, par_re;
   logic [CELL_W-1:0] par_wa, par_ra;
   logic [1:0]        par_wd, par_rd;
   logic              stk_we, stk_re;
   logic [CELL_W-1:0] stk_wa, stk_ra;
   logic [1:0]        stk_wd, stk_rd;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == gmbr_pkg::ST_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign is_load   = req_fire && (req_word.func == gmbr_pkg::FUNC_LOAD);
   assign is_fetch  = req_fire && (req_word.func == gmbr_pkg::FUNC_FETCH);

   always_comb begin
      if (rows_ff == '0) begin
         rows_eff = gmbr_pkg::ROWN_W'(1);
      end else if (32'(rows_ff) > gmbr_pkg::MAX_ROWS) begin
         rows_eff = gmbr_pkg::ROWN_W'(gmbr_pkg::MAX_ROWS);
      end else begin
         rows_eff = gmbr_pkg::ROWN_W'(rows_ff);
      end
      if (cols_ff == '0) begin
         cols_eff = gmbr_pkg::COLN_W'(1);
      end else if (32'(cols_ff) > gmbr_pkg::MAX_COLS) begin
         cols_eff = gmbr_pkg::COLN_W'(gmbr_pkg::MAX_COLS);
      end else begin
         cols_eff = gmbr_pkg::COLN_W'(cols_ff);
      end
   end

   assign cols_ext  = CNT_W'(cols_eff);
   assign total     = CNT_W'(CNT_W'(rows_eff) * cols_ext);
   assign last_cell = !(CNT_W'(load_pos_ff) + CNT_W'(1) < total);

   // start/target including the cell being loaded now
   always_comb begin
      start_upd  = (load_pos_ff == '0) ? '0 : start_ff;
      target_upd = (load_pos_ff == '0) ? '0 : target_ff;
      if (req_word.cell_kind == gmbr_pkg::KIND_START) begin
         start_upd = load_pos_ff;
      end
      if (req_word.cell_kind == gmbr_pkg::KIND_TARGET) begin
         target_upd = load_pos_ff;
      end
   end

   assign rem_sh = {rem_ff[REM_W-2:0], s_ff[bit_ff]};

   // neighbor order: down, up, right, left
   always_comb begin
      nb_ok = 1'b0;
      nb_u  = '0;
      nb_uc = vc_ff;
      nb_d  = gmbr_pkg::DIR_DOWN;
      case (k_ff)
         2'd0: begin
            nb_u  = CNT_W'(v_ff) + cols_ext;
            nb_ok = nb_u < total;
            nb_d  = gmbr_pkg::DIR_DOWN;
         end
         2'd1: begin
            nb_u  = CNT_W'(v_ff) - cols_ext;
            nb_ok = CNT_W'(v_ff) >= cols_ext;
            nb_d  = gmbr_pkg::DIR_UP;
         end
         2'd2: begin
            nb_u  = CNT_W'(v_ff) + CNT_W'(1);
            nb_uc = vc_ff + COL_W'(1);
            nb_ok = (CNT_W'(vc_ff) + CNT_W'(1)) < cols_ext;
            nb_d  = gmbr_pkg::DIR_RIGHT;
         end
         default: begin
            nb_u  = CNT_W'(v_ff) - CNT_W'(1);
            nb_uc = vc_ff - COL_W'(1);
            nb_ok = vc_ff != '0;
            nb_d  = gmbr_pkg::DIR_LEFT;
         end
      endcase
   end

   // backtrace step: undo the parent move; below zero wraps past total
   always_comb begin
      case (par_rd)
         gmbr_pkg::DIR_DOWN:  tr_next = cur_ff - cols_ext;
         gmbr_pkg::DIR_UP:    tr_next = cur_ff + cols_ext;
         gmbr_pkg::DIR_RIGHT: tr_next = cur_ff - CNT_W'(1);
         default:             tr_next = cur_ff + CNT_W'(1);
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gmbr_pkg::ST_IDLE: begin
            if (is_load && last_cell) begin
               state_in = gmbr_pkg::ST_DIV;
            end else if (is_fetch && moves_left_ff != '0) begin
               state_in = gmbr_pkg::ST_MOVE;
            end
         end
         gmbr_pkg::ST_DIV: begin
            if (bit_ff == '0) state_in = gmbr_pkg::ST_INIT;
         end
         gmbr_pkg::ST_INIT:    state_in = gmbr_pkg::ST_POP;
         gmbr_pkg::ST_POP: begin
            if (head_ff != tail_ff) begin
               state_in = gmbr_pkg::ST_FETCH_Q;
            end else if (found_ff) begin
               state_in = gmbr_pkg::ST_TR_RD;
            end else begin
               state_in = gmbr_pkg::ST_DONE;
            end
         end
         gmbr_pkg::ST_FETCH_Q: state_in = gmbr_pkg::ST_NB;
         gmbr_pkg::ST_NB: begin
            if (nb_ok) begin
               state_in = gmbr_pkg::ST_CHK;
            end else if (k_ff == 2'd3) begin
               state_in = gmbr_pkg::ST_POP;
            end
         end
         gmbr_pkg::ST_CHK: begin
            state_in = (k_ff == 2'd3) ? gmbr_pkg::ST_POP : gmbr_pkg::ST_NB;
         end
         gmbr_pkg::ST_TR_RD: begin
            if (cur_ff == CNT_W'(t_ff == s_ff ? t_ff : s_ff) || len_ff >= total) begin
               state_in = gmbr_pkg::ST_DONE;
            end else begin
               state_in = gmbr_pkg::ST_TR_WR;
            end
         end
         gmbr_pkg::ST_TR_WR: begin
            state_in = (tr_next >= total) ? gmbr_pkg::ST_DONE : gmbr_pkg::ST_TR_RD;
         end
         gmbr_pkg::ST_DONE:    state_in = gmbr_pkg::ST_IDLE;
         gmbr_pkg::ST_MOVE:    state_in = gmbr_pkg::ST_IDLE;
         default:              state_in = gmbr_pkg::ST_IDLE;
      endcase
   end

   // memory controls
   always_comb begin
      vis_we = 1'b0; vis_wa = u_ff; vis_wd = 1'b1;
      vis_re = 1'b0; vis_ra = nb_u[CELL_W-1:0];
      q_we   = 1'b0; q_wa = tail_ff[CELL_W-1:0]; q_wd = {u_ff, uc_ff};
      q_re   = 1'b0; q_ra = head_ff[CELL_W-1:0];
      par_we = 1'b0; par_wa = u_ff; par_wd = ud_ff;
      par_re = 1'b0; par_ra = cur_ff[CELL_W-1:0];
      stk_we = 1'b0; stk_wa = len_ff[CELL_W-1:0]; stk_wd = par_rd;
      stk_re = 1'b0; stk_ra = CELL_W'(moves_left_ff - CNT_W'(1));
      unique case (state_ff)
         gmbr_pkg::ST_IDLE: begin
            vis_we = is_load;
            vis_wa = load_pos_ff;
            vis_wd = req_word.cell_kind == gmbr_pkg::KIND_WALL;
            stk_re = is_fetch && moves_left_ff != '0;
         end
         gmbr_pkg::ST_INIT: begin
            vis_we = 1'b1;
            vis_wa = s_ff;
            q_we   = 1'b1;
            q_wa   = '0;
            q_wd   = {s_ff, rem_ff[COL_W-1:0]};
         end
         gmbr_pkg::ST_POP: q_re = head_ff != tail_ff;
         gmbr_pkg::ST_NB:  vis_re = nb_ok;
         gmbr_pkg::ST_CHK: begin
            vis_we = !vis_rd;
            par_we = !vis_rd;
            q_we   = !vis_rd && (tail_ff < CNT_W'(gmbr_pkg::CELLS));
         end
         gmbr_pkg::ST_TR_RD: par_re = 1'b1;
         gmbr_pkg::ST_TR_WR: stk_we = 1'b1;
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      load_pos_in   = load_pos_ff;
      start_in      = start_ff;
      target_in     = target_ff;
      moves_left_in = moves_left_ff;
      s_in = s_ff; t_in = t_ff;
      rem_in = rem_ff; bit_in = bit_ff;
      head_in = head_ff; tail_in = tail_ff;
      v_in = v_ff; vc_in = vc_ff; u_in = u_ff; uc_in = uc_ff; ud_in = ud_ff;
      k_in = k_ff; found_in = found_ff;
      cur_in = cur_ff; len_in = len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      case (state_ff)
         gmbr_pkg::ST_IDLE: begin
            if (is_load) begin
               start_in  = start_upd;
               target_in = target_upd;
               if (load_pos_ff == '0) moves_left_in = '0;
               if (last_cell) begin
                  load_pos_in = '0;
                  // start/target outside the grid fall back to cell 0
                  s_in   = (CNT_W'(start_upd) < total) ? start_upd : '0;
                  t_in   = (CNT_W'(target_upd) < total) ? target_upd : '0;
                  rem_in = '0;
                  bit_in = BIT_W'(CELL_W - 1);
               end else begin
                  load_pos_in = load_pos_ff + CELL_W'(1);
               end
            end
            if (is_fetch) begin
               if (moves_left_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '0;
                  rsp_in.result_kind = gmbr_pkg::RES_MOVE;
                  rsp_in.last_move   = 1'b1;
               end else begin
                  moves_left_in = moves_left_ff - CNT_W'(1);
               end
            end
         end
         gmbr_pkg::ST_DIV: begin
            // one quotient bit per cycle; only the remainder (column) is kept
            rem_in = (rem_sh >= REM_W'(cols_eff)) ? rem_sh - REM_W'(cols_eff) : rem_sh;
            bit_in = bit_ff - BIT_W'(1);
         end
         gmbr_pkg::ST_INIT: begin
            head_in  = '0;
            tail_in  = CNT_W'(1);
            found_in = s_ff == t_ff;
         end
         gmbr_pkg::ST_POP: begin
            if (head_ff != tail_ff) begin
               head_in = head_ff + CNT_W'(1);
            end else begin
               cur_in = CNT_W'(t_ff);
               len_in = '0;
            end
         end
         gmbr_pkg::ST_FETCH_Q: begin
            v_in  = q_rd[QUEUE_W-1:COL_W];
            vc_in = q_rd[COL_W-1:0];
            k_in  = 2'd0;
         end
         gmbr_pkg::ST_NB: begin
            u_in  = nb_u[CELL_W-1:0];
            uc_in = nb_uc;
            ud_in = nb_d;
            if (!nb_ok) k_in = k_ff + 2'd1;
         end
         gmbr_pkg::ST_CHK: begin
            if (!vis_rd) begin
               if (tail_ff < CNT_W'(gmbr_pkg::CELLS)) tail_in = tail_ff + CNT_W'(1);
               if (u_ff == t_ff) found_in = 1'b1;
            end
            k_in = k_ff + 2'd1;
         end
         gmbr_pkg::ST_TR_WR: begin
            len_in = len_ff + CNT_W'(1);
            cur_in = tr_next;
         end
         gmbr_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in = '0;
            rsp_in.result_kind = gmbr_pkg::RES_SUMMARY;
            rsp_in.reachable   = found_ff;
            rsp_in.path_length = found_ff ? gmbr_pkg::PATH_W'(len_ff) : '0;
            moves_left_in      = found_ff ? len_ff : '0;
         end
         gmbr_pkg::ST_MOVE: begin
            rsp_valid_in = 1'b1;
            rsp_in = '0;
            rsp_in.result_kind = gmbr_pkg::RES_MOVE;
            rsp_in.move_dir    = stk_rd;
            rsp_in.move_valid  = 1'b1;
            rsp_in.last_move   = moves_left_ff == '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gmbr_pkg::ST_IDLE;
         rows_ff       <= gmbr_pkg::CSR_W'(1);
         cols_ff       <= gmbr_pkg::CSR_W'(1);
         load_pos_ff   <= '0;
         start_ff      <= '0;
         target_ff     <= '0;
         moves_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_pos_ff   <= load_pos_in;
         start_ff      <= start_in;
         target_ff     <= target_in;
         moves_left_ff <= moves_left_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               gmbr_pkg::CSR_ROWS: rows_ff <= csr_data;
               gmbr_pkg::CSR_COLS: cols_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in; t_ff <= t_in;
      rem_ff <= rem_in; bit_ff <= bit_in;
      head_ff <= head_in; tail_ff <= tail_in;
      v_ff <= v_in; vc_ff <= vc_in;
      u_ff <= u_in; uc_ff <= uc_in; ud_ff <= ud_in;
      k_ff <= k_in; found_ff <= found_in;
      cur_ff <= cur_in; len_ff <= len_in;
      rsp_ff <= rsp_in;
   end

   gmbr_ram #(.WIDTH(1), .DEPTH(gmbr_pkg::CELLS)) u_visited (
      .clock(clock), .wr_en(vis_we), .wr_addr(vis_wa), .wr_data(vis_wd),
      .rd_en(vis_re), .rd_addr(vis_ra), .rd_data(vis_rd)
   );

   gmbr_ram #(.WIDTH(2), .DEPTH(gmbr_pkg::CELLS)) u_parent (
      .clock(clock), .wr_en(par_we), .wr_addr(par_wa), .wr_data(par_wd),
      .rd_en(par_re), .rd_addr(par_ra), .rd_data(par_rd)
   );

   gmbr_ram #(.WIDTH(QUEUE_W), .DEPTH(gmbr_pkg::CELLS)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_en(q_re), .rd_addr(q_ra), .rd_data(q_rd)
   );

   gmbr_ram #(.WIDTH(2), .DEPTH(gmbr_pkg::CELLS)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_en(stk_re), .rd_addr(stk_ra), .rd_data(stk_rd)
   );

endmodule

// ===== rtl/core/gmbr_checker.sv =====
module gmbr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input gmbr_pkg::rsp_type rsp_word
);

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // out of reset: nothing pending, ready for a word
   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

   // no intake while the output register is blocked
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req taken while rsp blocked");

   // unreachable summary carries no length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.result_kind == gmbr_pkg::RES_SUMMARY && !rsp_word.reachable
      |-> rsp_word.path_length == '0)
      else $error("unreachable with nonzero length");

endmodule

bind grid_maze_bfs_router gmbr_checker u_gmbr_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_word(rsp_word)
);
